FILE: src/i2ctt_pkg.sv
// ---------------------------------------------------------------------------
// i2ctt_pkg
// Shared types and codes of the I2C target transaction sequencer.
// ---------------------------------------------------------------------------
package i2ctt_pkg;

  localparam int IN_DATA_W  = 40;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 40;

  typedef enum logic [1:0] {
    REQ_BUS   = 2'd0,
    REQ_LOAD  = 2'd1,
    REQ_ARM   = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_TOO_MANY  = 2'd1,
    ERR_NOT_READY = 2'd2,
    ERR_FULL      = 2'd3
  } err_t;

  typedef enum logic [1:0] {
    BUS_IDLE   = 2'd0,
    BUS_MWRITE = 2'd1,
    BUS_MREAD  = 2'd2,
    BUS_NOMSG  = 2'd3
  } bus_code_t;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'b0001,
    PH_MWRITE = 4'b0010,
    PH_MREAD  = 4'b0100,
    PH_NOMSG  = 4'b1000
  } phase_t;

  typedef struct packed {
    req_t       req_type;
    logic       is_data;
    logic       start_seen;
    logic       stop_seen;
    logic       rx_full;
    logic       master_reads;
    logic [7:0] rx_byte;
    logic [4:0] tx_index;
    logic [7:0] tx_value;
    logic [5:0] tx_length;
    logic       tx_present;
  } item_t;

  typedef struct packed {
    logic       tx_load;
    logic [7:0] tx_byte;
    logic       rx_store;
    logic [4:0] rx_index;
    logic [5:0] rx_count;
    logic       address_capture;
    logic [7:0] address_byte;
    logic       rx_message_done;
    logic       tx_message_done;
    err_t       error_code;
    bus_code_t  bus_state;
    logic       tx_handled;
  } result_t;

  function automatic bus_code_t phase_code(input phase_t ph);
    bus_code_t code;
    unique case (ph)
      PH_MWRITE: code = BUS_MWRITE;
      PH_MREAD:  code = BUS_MREAD;
      PH_NOMSG:  code = BUS_NOMSG;
      default:   code = BUS_IDLE;
    endcase
    return code;
  endfunction

endpackage

FILE: src/i2ctt_seq.sv
// ---------------------------------------------------------------------------
// i2ctt_seq
// Next-state and result logic for one request word of the sequencer.
// ---------------------------------------------------------------------------
module i2ctt_seq
  import i2ctt_pkg::*;
#(
  parameter int RX_DEPTH = 32,
  parameter int TX_DEPTH = 32,
  parameter int CW       = 6
) (
  input  item_t         item,
  input  phase_t        phase,
  input  logic [CW-1:0] tc,
  input  logic [CW-1:0] tx_len,
  input  logic          tx_exists,
  input  logic          tx_ready,
  input  logic [7:0]    rd_byte,
  input  logic [7:0]    slot0,
  output phase_t        phase_nxt,
  output logic [CW-1:0] tc_nxt,
  output logic [CW-1:0] tx_len_nxt,
  output logic          tx_exists_nxt,
  output logic          tx_ready_nxt,
  output result_t       res
);

  localparam int CMPW = (CW > 6) ? CW : 6;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_ADDR   = 2'd1,
    EV_RSTART = 2'd2,
    EV_STOP   = 2'd3
  } ev_t;

  ev_t             ev;
  logic            rstart;
  logic [CMPW-1:0] tc_w;
  logic [CMPW-1:0] tc_inc;
  logic [CMPW-1:0] len_w;
  logic [CMPW-1:0] arm_len;

  always_comb begin
    rstart = !item.is_data && item.start_seen && item.rx_full;
    len_w  = CMPW'(tx_len);
    arm_len = (CMPW'(item.tx_length) > CMPW'(TX_DEPTH)) ? CMPW'(TX_DEPTH)
                                                         : CMPW'(item.tx_length);

    phase_nxt     = phase;
    tc_nxt        = tc;
    tx_len_nxt    = tx_len;
    tx_exists_nxt = tx_exists;
    tx_ready_nxt  = tx_ready;
    res           = '0;
    ev            = EV_NONE;
    tc_w          = CMPW'(tc);
    tc_inc        = '0;

    unique case (item.req_type)
      REQ_ARM: begin
        tx_len_nxt    = arm_len[CW-1:0];
        tx_exists_nxt = item.tx_present;
        tx_ready_nxt  = item.tx_present;
      end
      REQ_BUS: begin
        unique case (phase)
          PH_IDLE: begin
            tc_w = '0;
            if (!item.is_data && item.start_seen) ev = EV_ADDR;
          end
          PH_MWRITE: begin
            if (rstart) begin
              res.rx_message_done = 1'b1;
              ev = EV_RSTART;
            end else if (item.stop_seen) begin
              res.rx_message_done = 1'b1;
              ev = EV_STOP;
            end
          end
          PH_MREAD: begin
            if (rstart) begin
              res.tx_message_done = 1'b1;
              ev = EV_RSTART;
            end else if (item.stop_seen) begin
              res.tx_message_done = 1'b1;
              ev = EV_STOP;
            end
          end
          PH_NOMSG: begin
            if (item.stop_seen) ev = EV_STOP;
          end
          default: ev = EV_NONE;
        endcase

        if (ev == EV_RSTART) tc_w = '0;
        tc_nxt = tc_w[CW-1:0];

        if (ev == EV_ADDR || ev == EV_RSTART) begin
          res.address_capture = 1'b1;
          res.address_byte    = item.rx_byte;
          if (!item.master_reads) begin
            phase_nxt = PH_MWRITE;
          end else if (!tx_exists) begin
            phase_nxt = PH_NOMSG;
          end else begin
            phase_nxt   = PH_MREAD;
            res.tx_load = 1'b1;
            // The count is zero here, so the first byte always comes from slot 0.
            // Reaching the last byte this way does not mark the message handled.
            if (tx_ready) begin
              if (len_w != '0) begin
                res.tx_byte = slot0;
                tc_nxt      = CW'(1);
              end
            end else begin
              res.error_code = ERR_NOT_READY;
            end
          end
        end else if (ev == EV_STOP) begin
          phase_nxt = PH_IDLE;
        end else if (phase == PH_MREAD) begin
          res.tx_load = 1'b1;
          if (tx_ready) begin
            if (tc_w < len_w) begin
              tc_inc      = tc_w + CMPW'(1);
              res.tx_byte = rd_byte;
              tc_nxt      = tc_inc[CW-1:0];
              if (tc_inc == len_w) begin
                tx_ready_nxt   = 1'b0;
                res.tx_handled = 1'b1;
              end
            end else begin
              res.error_code = ERR_TOO_MANY;
            end
          end else begin
            res.error_code = ERR_NOT_READY;
          end
        end else if (phase == PH_MWRITE) begin
          if (tc_w < CMPW'(RX_DEPTH)) begin
            tc_inc       = tc_w + CMPW'(1);
            res.rx_store = 1'b1;
            res.rx_index = tc_w[4:0];
            res.rx_count = tc_inc[5:0];
            tc_nxt       = tc_inc[CW-1:0];
          end else begin
            res.error_code = ERR_FULL;
          end
        end
      end
      default: begin
      end
    endcase

    res.bus_state = phase_code(phase_nxt);
  end

endmodule

FILE: src/i2c_target_transaction_fsm.sv
// ---------------------------------------------------------------------------
// i2c_target_transaction_fsm
// Transaction sequencer of an I2C target: tracks the bus phase, counts
// received bytes and serves bytes from the transmit buffer.
// ---------------------------------------------------------------------------
//   channel   direction  payload
//   in_       slave      tuser: request kind, tdata: status bits, bytes
//   out_      master     tdata: one result word per request word
//
// One request word is taken per cycle unless out_tready stalls; each one
// produces one result word. A word sits in the input register, is worked in
// one pass through the sequencer logic and lands in the output register. The
// transmit buffer read is prefetched at the count left by the previous word.
// rst_n clears the phase, counters and handshake state; the transmit buffer
// holds no reset value. A stall on out_tready holds both registers.
// ---------------------------------------------------------------------------
module i2c_target_transaction_fsm
  import i2ctt_pkg::*;
#(
  parameter int RX_DEPTH = 32,
  parameter int TX_DEPTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // Fields from bit 0: is_data, start_seen, stop_seen, rx_full, master_reads,
  // rx_byte[7:0], tx_index[4:0], tx_value[7:0], tx_length[5:0], tx_present.
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // Fields from bit 0: req_type[1:0].
  input  logic [IN_USER_W-1:0]  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // Fields from bit 0: tx_load, tx_byte[7:0], rx_store, rx_index[4:0],
  // rx_count[5:0], address_capture, address_byte[7:0], rx_message_done,
  // tx_message_done, error_code[1:0], bus_state[1:0], tx_handled.
  output logic [OUT_DATA_W-1:0] out_tdata
);

  localparam int MAXD = (RX_DEPTH > TX_DEPTH) ? RX_DEPTH : TX_DEPTH;
  localparam int CW   = $clog2(MAXD + 1);
  localparam int AW   = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
  localparam int IXW  = (AW > 5) ? AW : 5;
  localparam int TCW  = (CW > AW) ? CW : AW;

  item_t         in_item;
  item_t         item_r;
  logic          s1_valid_r;
  result_t       out_r;
  logic          out_valid_r;
  logic          advance;

  phase_t        phase_r;
  logic [CW-1:0] tc_r;
  logic [CW-1:0] tx_len_r;
  logic          tx_exists_r;
  logic          tx_ready_r;
  phase_t        phase_nxt;
  logic [CW-1:0] tc_nxt;
  logic [CW-1:0] tx_len_nxt;
  logic          tx_exists_nxt;
  logic          tx_ready_nxt;
  result_t       res;

  logic [7:0]    tx_mem [TX_DEPTH];
  logic [7:0]    rd_r;
  logic [7:0]    slot0_r;
  logic [IXW-1:0] idx_ext;
  logic [AW-1:0] wr_addr;
  logic          wr_en;
  logic [TCW-1:0] tc_ext;
  logic [CW-1:0] tc_next_count;
  logic [AW-1:0] rd_addr;

  assign in_item.is_data      = in_tdata[0];
  assign in_item.start_seen   = in_tdata[1];
  assign in_item.stop_seen    = in_tdata[2];
  assign in_item.rx_full      = in_tdata[3];
  assign in_item.master_reads = in_tdata[4];
  assign in_item.rx_byte      = in_tdata[12:5];
  assign in_item.tx_index     = in_tdata[17:13];
  assign in_item.tx_value     = in_tdata[25:18];
  assign in_item.tx_length    = in_tdata[31:26];
  assign in_item.tx_present   = in_tdata[32];
  assign in_item.req_type     = req_t'(in_tuser);

  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;

  i2ctt_seq #(
    .RX_DEPTH (RX_DEPTH),
    .TX_DEPTH (TX_DEPTH),
    .CW       (CW)
  ) u_seq (
    .item          (item_r),
    .phase         (phase_r),
    .tc            (tc_r),
    .tx_len        (tx_len_r),
    .tx_exists     (tx_exists_r),
    .tx_ready      (tx_ready_r),
    .rd_byte       (rd_r),
    .slot0         (slot0_r),
    .phase_nxt     (phase_nxt),
    .tc_nxt        (tc_nxt),
    .tx_len_nxt    (tx_len_nxt),
    .tx_exists_nxt (tx_exists_nxt),
    .tx_ready_nxt  (tx_ready_nxt),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= PH_IDLE;
      tc_r        <= '0;
      tx_len_r    <= '0;
      tx_exists_r <= 1'b0;
      tx_ready_r  <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        phase_r     <= phase_nxt;
        tc_r        <= tc_nxt;
        tx_len_r    <= tx_len_nxt;
        tx_exists_r <= tx_exists_nxt;
        tx_ready_r  <= tx_ready_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) item_r <= in_item;
    if (advance) out_r <= res;
  end

  // Transmit buffer: loads are written as they pass the sequencer.
  always_comb begin
    idx_ext = IXW'(item_r.tx_index);
    wr_addr = idx_ext[AW-1:0];
    wr_en   = advance && (item_r.req_type == REQ_LOAD) &&
              (9'(item_r.tx_index) < 9'(TX_DEPTH));
    tc_next_count = advance ? tc_nxt : tc_r;
    tc_ext  = TCW'(tc_next_count);
    rd_addr = tc_ext[AW-1:0];
  end

  // The read register always holds the slot at the current count, so the
  // sequencer sees it without a wait. A load to that slot is forwarded.
  always_ff @(posedge clk) begin
    if (wr_en) tx_mem[wr_addr] <= item_r.tx_value;
    if (wr_en && (wr_addr == rd_addr)) begin
      rd_r <= item_r.tx_value;
    end else begin
      rd_r <= tx_mem[rd_addr];
    end
    if (wr_en && (wr_addr == '0)) slot0_r <= item_r.tx_value;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000,
                       out_r.tx_handled,
                       out_r.bus_state,
                       out_r.error_code,
                       out_r.tx_message_done,
                       out_r.rx_message_done,
                       out_r.address_byte,
                       out_r.address_capture,
                       out_r.rx_count,
                       out_r.rx_index,
                       out_r.rx_store,
                       out_r.tx_byte,
                       out_r.tx_load};

endmodule
